// ----- rtl/multi_band_token_bucket_meter_assert.svh -----
// Assertion helpers for the token bucket meter.
// Each expects clk_i and rst_ni in scope.
`ifndef MULTI_BAND_TOKEN_BUCKET_METER_ASSERT_SVH
`define MULTI_BAND_TOKEN_BUCKET_METER_ASSERT_SVH

// Same-cycle implication.
`define MBTBM_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("meter assertion failed");

// Next-cycle implication.
`define MBTBM_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("meter assertion failed");

`endif

// ----- rtl/mbtbm_pkg.sv -----
package mbtbm_pkg;

  // Band storage
  localparam int NUM_BANDS = 4;
  localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CNT_W     = $clog2(NUM_BANDS + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_PPS_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGED_COST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGED_CAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGED_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGED_DSCP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_WR_INDEX = 3'd6;

  // Verdict codes
  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DROP   = 2'd1;
  localparam logic [1:0] VERDICT_REMARK = 2'd2;

  typedef struct packed {
    logic [63:0] timestamp_ns;
    logic [15:0] packet_len;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  chosen_band;
    logic [63:0] meter_packets;
    logic [63:0] meter_bytes;
    logic [63:0] band_dropped_packets;
    logic [63:0] band_dropped_bytes;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_CHARGE,
    ST_FINISH
  } state_e;

endpackage

// ----- rtl/multi_band_token_bucket_meter.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   mbtbm_pkg::in_t  (timestamp, length)
// out      output     out_valid_o/out_stall_i mbtbm_pkg::out_t (verdict, counters)
// cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One shared refill/charge datapath visits the active bands in turn, each in a
// refill step (refill and multiply) and a charge step (pay and rank), then ends
// in a finish step; with no bands a packet goes straight to finish. The input
// stalls until the block is idle again. A stalled output holds the finish step
// until the register frees. Reset clears control, tokens and all counters; band
// tables hold garbage until their band is committed.
module multi_band_token_bucket_meter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mbtbm_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mbtbm_pkg::out_t                      out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [mbtbm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mbtbm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mbtbm_pkg::*;

  // Configuration registers
  logic        pps_mode_q;
  logic [2:0]  band_count_q;
  logic [31:0] staged_cost_q;
  logic [62:0] staged_cap_q;
  logic [62:0] staged_rate_q;
  logic        staged_dscp_q;

  // Band tables
  logic [31:0] cost_tbl_q [NUM_BANDS];
  logic [62:0] cap_tbl_q  [NUM_BANDS];
  logic [62:0] rate_tbl_q [NUM_BANDS];
  logic        dscp_tbl_q [NUM_BANDS];
  logic [62:0] tokens_q   [NUM_BANDS];
  logic [63:0] drop_pkts_q  [NUM_BANDS];
  logic [63:0] drop_bytes_q [NUM_BANDS];

  // Global state
  logic [63:0] last_time_q;
  logic [63:0] total_pkts_q;
  logic [63:0] total_bytes_q;

  // Per-packet working registers
  state_e            state_q, state_d;
  logic [BAND_W-1:0] idx_q;
  logic [BAND_W-1:0] best_q;
  logic              any_q;
  logic [62:0]       best_rate_q;
  logic [63:0]       elapsed_q;
  logic [15:0]       len_q;
  logic [47:0]       cost_q;
  logic [62:0]       sum_q;

  logic              out_valid_q;
  out_t              out_q;

  logic              in_xfer;
  logic              load_out;
  logic [CNT_W-1:0]  n_active;
  logic              last_band;
  logic              commit_en;
  logic [BAND_W-1:0] commit_band;
  logic [64:0]       refill_sum;
  logic [62:0]       refill_capped;
  logic              drop_now;
  logic [63:0]       new_drop_pkts;
  logic [63:0]       new_drop_bytes;

  // Clamp the band count to the storage depth
  assign n_active = (band_count_q > 3'(NUM_BANDS)) ? CNT_W'(NUM_BANDS)
                                                   : CNT_W'(band_count_q);
  assign last_band = (CNT_W'(idx_q) + CNT_W'(1)) == n_active;

  assign commit_en   = cfg_we_i && (cfg_idx_i == CFG_BAND_WR_INDEX)
                       && (int'(cfg_wdata_i[1:0]) < NUM_BANDS);
  assign commit_band = BAND_W'(cfg_wdata_i[1:0]);

  // Refill: tokens plus elapsed, capped (overflow past 2^64 also caps)
  assign refill_sum    = {2'b00, tokens_q[idx_q]} + {1'b0, elapsed_q};
  assign refill_capped = (refill_sum > {2'b00, cap_tbl_q[idx_q]}) ? cap_tbl_q[idx_q]
                                                                  : refill_sum[62:0];
  assign drop_now      = sum_q < 63'(cost_q);

  assign new_drop_pkts  = drop_pkts_q[best_q] + 64'd1;
  assign new_drop_bytes = drop_bytes_q[best_q] + 64'(len_q);

  assign in_xfer = in_valid_i && !in_stall_o;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (n_active == '0) ? ST_FINISH : ST_REFILL;
        end
      end
      ST_REFILL: begin
        state_d = ST_CHARGE;
      end
      ST_CHARGE: begin
        state_d = last_band ? ST_FINISH : ST_REFILL;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, tokens and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_mode_q    <= 1'b0;
      band_count_q  <= '0;
      staged_cost_q <= '0;
      staged_cap_q  <= '0;
      staged_rate_q <= '0;
      staged_dscp_q <= 1'b0;
      last_time_q   <= '0;
      total_pkts_q  <= '0;
      total_bytes_q <= '0;
      idx_q         <= '0;
      best_q        <= '0;
      any_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        tokens_q[b]     <= '0;
        drop_pkts_q[b]  <= '0;
        drop_bytes_q[b] <= '0;
      end
    end else begin
      // Register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PPS_MODE:    pps_mode_q    <= cfg_wdata_i[0];
          CFG_BAND_COUNT:  band_count_q  <= cfg_wdata_i[2:0];
          CFG_STAGED_COST: staged_cost_q <= cfg_wdata_i[31:0];
          CFG_STAGED_CAP:  staged_cap_q  <= cfg_wdata_i[62:0];
          CFG_STAGED_RATE: staged_rate_q <= cfg_wdata_i[62:0];
          CFG_STAGED_DSCP: staged_dscp_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (commit_en) begin
        tokens_q[commit_band] <= staged_cap_q;
      end

      // Packet transfer: totals, time base, scan setup
      if (in_xfer) begin
        total_pkts_q  <= total_pkts_q + 64'd1;
        total_bytes_q <= total_bytes_q + 64'(in_data_i.packet_len);
        if (n_active != '0) begin
          last_time_q <= in_data_i.timestamp_ns;
        end
        idx_q  <= '0;
        best_q <= '0;
        any_q  <= 1'b0;
      end

      // Pay or mark drop, rank by rate
      if (state_q == ST_CHARGE) begin
        tokens_q[idx_q] <= drop_now ? sum_q : (sum_q - 63'(cost_q));
        if (drop_now) begin
          any_q <= 1'b1;
          if (rate_tbl_q[idx_q] > best_rate_q) begin
            best_q <= idx_q;
          end
        end
        idx_q <= idx_q + BAND_W'(1);
      end

      // Result transfer and drop counter update
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (any_q) begin
          drop_pkts_q[best_q]  <= new_drop_pkts;
          drop_bytes_q[best_q] <= new_drop_bytes;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and tables
  always_ff @(posedge clk_i) begin
    if (commit_en) begin
      cost_tbl_q[commit_band] <= staged_cost_q;
      cap_tbl_q[commit_band]  <= staged_cap_q;
      rate_tbl_q[commit_band] <= staged_rate_q;
      dscp_tbl_q[commit_band] <= staged_dscp_q;
    end
    if (in_xfer) begin
      elapsed_q   <= in_data_i.timestamp_ns - last_time_q;
      len_q       <= in_data_i.packet_len;
      best_rate_q <= '0;
    end
    if (state_q == ST_REFILL) begin
      sum_q  <= refill_capped;
      cost_q <= pps_mode_q ? 48'(cost_tbl_q[idx_q]) : (cost_tbl_q[idx_q] * len_q);
    end
    if (state_q == ST_CHARGE && drop_now && (rate_tbl_q[idx_q] > best_rate_q)) begin
      best_rate_q <= rate_tbl_q[idx_q];
    end
    if (load_out) begin
      out_q.meter_packets <= total_pkts_q;
      out_q.meter_bytes   <= total_bytes_q;
      if (any_q) begin
        out_q.verdict              <= dscp_tbl_q[best_q] ? VERDICT_REMARK : VERDICT_DROP;
        out_q.chosen_band          <= 2'(best_q);
        out_q.band_dropped_packets <= new_drop_pkts;
        out_q.band_dropped_bytes   <= new_drop_bytes;
      end else begin
        out_q.verdict              <= VERDICT_ACCEPT;
        out_q.chosen_band          <= '0;
        out_q.band_dropped_packets <= '0;
        out_q.band_dropped_bytes   <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "multi_band_token_bucket_meter_assert.svh"

  // A transfer starts the band scan, or goes straight to finish with no bands
  `MBTBM_ASSERT_NEXT(a_xfer_starts, in_xfer, (state_q == ST_REFILL) || (state_q == ST_FINISH))

  // The scan index never runs past the active band count
  `MBTBM_ASSERT_NOW(a_idx_in_range, (state_q == ST_REFILL) || (state_q == ST_CHARGE),
                    CNT_W'(idx_q) < n_active)

  // Finishing with a free output register always presents a result
  `MBTBM_ASSERT_NEXT(a_finish_loads, load_out, out_valid_q && (state_q == ST_IDLE))

  // An accepted packet reports no drop band and no drop counts
  `MBTBM_ASSERT_NOW(a_accept_clean, out_valid_q && (out_q.verdict == VERDICT_ACCEPT),
                    (out_q.chosen_band == '0) && (out_q.band_dropped_packets == '0))

endmodule

// ----- verif/mbtbm_verdict_checker.sv -----
// Watches the packet, result and config ports of the meter, keeps its own
// copy of the band state and compares every result against its prediction.
module mbtbm_verdict_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  mbtbm_pkg::in_t                  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  mbtbm_pkg::out_t                 out_data_i,
  input  logic                            cfg_we_i,
  input  logic [mbtbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbtbm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              errors_o,
  output int                              pending_o
);
  import mbtbm_pkg::*;

  localparam int REPORT_MAX = 10;

  // Control and staged band parameters
  logic        pps_q;
  logic [2:0]  band_cnt_q;
  logic [31:0] stg_cost;
  logic [62:0] stg_cap;
  logic [62:0] stg_rate;
  logic        stg_dscp;

  // Committed band tables and bucket levels
  logic [31:0] cost_tbl [NUM_BANDS];
  logic [62:0] cap_tbl  [NUM_BANDS];
  logic [62:0] rate_tbl [NUM_BANDS];
  logic        dscp_tbl [NUM_BANDS];
  logic [62:0] tokens   [NUM_BANDS];

  // Timestamps and counters
  logic [63:0] last_ts;
  logic [63:0] pkt_total;
  logic [63:0] byte_total;
  logic [63:0] drop_pkts  [NUM_BANDS];
  logic [63:0] drop_bytes [NUM_BANDS];

  out_t verdict_q[$];
  int   results_seen;

  // Config write as the block applies it
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
    logic [1:0] band;
    band = wdata[1:0];
    case (idx)
      CFG_PPS_MODE:    pps_q = wdata[0];
      CFG_BAND_COUNT:  band_cnt_q = wdata[2:0];
      CFG_STAGED_COST: stg_cost = wdata[31:0];
      CFG_STAGED_CAP:  stg_cap = wdata[62:0];
      CFG_STAGED_RATE: stg_rate = wdata[62:0];
      CFG_STAGED_DSCP: stg_dscp = wdata[0];
      CFG_BAND_WR_INDEX: begin
        cost_tbl[band] = stg_cost;
        cap_tbl[band]  = stg_cap;
        rate_tbl[band] = stg_rate;
        dscp_tbl[band] = stg_dscp;
        tokens[band]   = stg_cap;
      end
      default: ;
    endcase
  endfunction

  // Meter one packet: refill, charge every active band, pick the dropping band
  function automatic out_t meter_packet(in_t pkt);
    out_t        res;
    logic [63:0] elapsed;
    logic [63:0] cost;
    logic [63:0] level;
    logic [64:0] sum;
    logic [62:0] best_rate;
    logic [1:0]  best;
    logic        any_drop;
    int          active;
    int          b;
    res = '0;
    res.verdict = VERDICT_ACCEPT;
    active = (int'(band_cnt_q) > NUM_BANDS) ? NUM_BANDS : int'(band_cnt_q);
    pkt_total  = pkt_total + 64'd1;
    byte_total = byte_total + 64'(pkt.packet_len);
    if (active != 0) begin
      elapsed   = pkt.timestamp_ns - last_ts;
      best_rate = '0;
      best      = '0;
      any_drop  = 1'b0;
      for (b = 0; b < active; b++) begin
        cost = pps_q ? 64'(cost_tbl[b]) : 64'(cost_tbl[b]) * 64'(pkt.packet_len);
        sum  = {2'b00, tokens[b]} + {1'b0, elapsed};
        // saturating refill, capped at the bucket size
        if (sum[64] || sum[63:0] > {1'b0, cap_tbl[b]})
          level = {1'b0, cap_tbl[b]};
        else
          level = sum[63:0];
        if (level < cost) begin
          tokens[b] = level[62:0];
          if (rate_tbl[b] > best_rate) begin
            best_rate = rate_tbl[b];
            best      = 2'(b);
          end
          any_drop = 1'b1;
        end else begin
          tokens[b] = 63'(level - cost);
        end
      end
      last_ts = pkt.timestamp_ns;
      if (any_drop) begin
        drop_pkts[best]  = drop_pkts[best] + 64'd1;
        drop_bytes[best] = drop_bytes[best] + 64'(pkt.packet_len);
        res.verdict   = dscp_tbl[best] ? VERDICT_REMARK : VERDICT_DROP;
        res.chosen_band = best;
        res.band_dropped_packets = drop_pkts[best];
        res.band_dropped_bytes   = drop_bytes[best];
      end
    end
    res.meter_packets = pkt_total;
    res.meter_bytes   = byte_total;
    return res;
  endfunction

  // Track transfers on all three ports
  always @(posedge clk_i or negedge rst_ni) begin
    out_t  exp_res;
    string bad;
    int    k;
    if (!rst_ni) begin
      pps_q = 1'b0;
      band_cnt_q = '0;
      stg_cost = '0;
      stg_cap = '0;
      stg_rate = '0;
      stg_dscp = 1'b0;
      last_ts = '0;
      pkt_total = '0;
      byte_total = '0;
      for (k = 0; k < NUM_BANDS; k++) begin
        cost_tbl[k] = '0;
        cap_tbl[k] = '0;
        rate_tbl[k] = '0;
        dscp_tbl[k] = 1'b0;
        tokens[k] = '0;
        drop_pkts[k] = '0;
        drop_bytes[k] = '0;
      end
      verdict_q.delete();
      results_seen = 0;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i)
        apply_cfg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i)
        verdict_q.push_back(meter_packet(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          if (errors_o < REPORT_MAX)
            $display("result %0d arrived with nothing expected", results_seen);
          errors_o++;
        end else begin
          exp_res = verdict_q.pop_front();
          bad = "";
          if (out_data_i.verdict !== exp_res.verdict) bad = {bad, " verdict"};
          if (out_data_i.chosen_band !== exp_res.chosen_band) bad = {bad, " chosen_band"};
          if (out_data_i.meter_packets !== exp_res.meter_packets)
            bad = {bad, " meter_packets"};
          if (out_data_i.meter_bytes !== exp_res.meter_bytes) bad = {bad, " meter_bytes"};
          if (out_data_i.band_dropped_packets !== exp_res.band_dropped_packets)
            bad = {bad, " band_dropped_packets"};
          if (out_data_i.band_dropped_bytes !== exp_res.band_dropped_bytes)
            bad = {bad, " band_dropped_bytes"};
          if (bad != "") begin
            if (errors_o < REPORT_MAX) begin
              $display("result %0d mismatch in%s", results_seen, bad);
              $display("  expected verdict=%0d band=%0d pkts=%0d bytes=%0d dpkts=%0d dbytes=%0d",
                       exp_res.verdict, exp_res.chosen_band, exp_res.meter_packets,
                       exp_res.meter_bytes, exp_res.band_dropped_packets,
                       exp_res.band_dropped_bytes);
              $display("  actual   verdict=%0d band=%0d pkts=%0d bytes=%0d dpkts=%0d dbytes=%0d",
                       out_data_i.verdict, out_data_i.chosen_band, out_data_i.meter_packets,
                       out_data_i.meter_bytes, out_data_i.band_dropped_packets,
                       out_data_i.band_dropped_bytes);
            end
            errors_o++;
          end
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

// ----- verif/tb_multi_band_token_bucket_meter.sv -----
module tb_multi_band_token_bucket_meter;
  import mbtbm_pkg::*;

  localparam int          GAP_MAX     = 12;
  localparam int          STALL_MAX   = 12;
  localparam int          SETTLE      = 24;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 96;
  localparam logic [62:0] CAP_TOP     = 63'h4000_0000_0000_0000;
  localparam logic [62:0] RATE_TOP    = '1;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int          errors;
  int          pending;
  int          cycles = 0;
  int          stall_left = 0;
  logic        took_result = 1'b0;
  logic        gaps_on = 1'b0;
  logic        stalls_on = 1'b0;
  logic [63:0] ts_now = '0;

  multi_band_token_bucket_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mbtbm_verdict_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: after each result transfer, may stall the output at random when stalls are on
  always @(posedge clk_i) took_result <= out_valid_o && !out_stall_i;

  always @(negedge clk_i) begin
    if (took_result)
      stall_left = stalls_on ? $urandom_range(0, STALL_MAX) : 0;
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stage one band's parameters and commit them
  task automatic commit_band(input logic [1:0] band, input logic [31:0] cost,
                             input logic [62:0] cap, input logic [62:0] rate,
                             input logic dscp);
    cfg_write(CFG_STAGED_COST, 64'(cost));
    cfg_write(CFG_STAGED_CAP, 64'(cap));
    cfg_write(CFG_STAGED_RATE, 64'(rate));
    cfg_write(CFG_STAGED_DSCP, 64'(dscp));
    cfg_write(CFG_BAND_WR_INDEX, 64'(band));
  endtask

  // One packet transfer, preceded by an optional random gap
  task automatic send_packet(input logic [63:0] ts, input logic [15:0] len);
    int gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {ts, len};
    do @(posedge clk_i); while (in_stall_o);
    ts_now = ts;
  endtask

  // Hold off until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Random band setup for one phase
  task automatic reconfigure(input bit all_bands);
    logic        pps;
    logic [31:0] cost;
    logic [62:0] cap;
    logic [62:0] rate;
    logic [2:0]  cnt;
    int          sel;
    int          b;
    pps = 1'($urandom_range(0, 1));
    cfg_write(CFG_PPS_MODE, 64'(pps));
    for (b = 0; b < NUM_BANDS; b++) begin
      if (all_bands || $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 15);
        if (sel == 0) cost = '0;
        else if (sel == 1) cost = '1;
        else cost = pps ? $urandom_range(1, 200000) : $urandom_range(1, 64);
        sel = $urandom_range(0, 15);
        if (sel == 0) cap = '0;
        else if (sel == 1) cap = CAP_TOP;
        else if (sel == 2) cap = 63'({$urandom, $urandom}) >> 1;
        else cap = 63'($urandom_range(1, 4000000));
        sel = $urandom_range(0, 15);
        if (sel == 0) rate = '0;
        else if (sel == 1) rate = RATE_TOP;
        else if (sel == 2) rate = 63'({$urandom, $urandom});
        else rate = 63'($urandom_range(0, 3));
        commit_band(2'(b), cost, cap, rate, 1'($urandom_range(0, 1)));
      end
    end
    sel = $urandom_range(0, 15);
    if (sel == 0) cnt = '0;
    else if (sel == 1) cnt = 3'($urandom_range(5, 7));
    else if (sel < 6) cnt = 3'($urandom_range(1, 3));
    else cnt = 3'd4;
    cfg_write(CFG_BAND_COUNT, 64'(cnt));
    cfg_done();
  endtask

  initial begin
    logic [63:0] ts;
    logic [15:0] len;
    int          p;
    int          i;
    int          sel;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No bands: everything accepted, only totals move
    send_packet(64'd0, 16'd0);
    send_packet('1, 16'hFFFF);
    send_packet(64'h5555_5555_5555_5555, 16'hAAAA);
    drain();

    // Byte mode, four bands: drops, remark, wrap and refill saturation
    commit_band(2'd0, 32'd1, 63'd1000, 63'd0, 1'b0);
    commit_band(2'd1, 32'd1, 63'd500, 63'd7, 1'b1);
    commit_band(2'd2, 32'd0, 63'd0, RATE_TOP, 1'b0);
    commit_band(2'd3, 32'hFFFF_FFFF, CAP_TOP, 63'd7, 1'b1);
    cfg_write(CFG_BAND_COUNT, 64'd4);
    cfg_done();
    send_packet(64'd0, 16'd0);
    send_packet(64'd0, 16'd400);
    send_packet(64'd0, 16'd200);
    send_packet(64'd0, 16'd700);
    send_packet('1, 16'hFFFF);
    send_packet(64'd5, 16'd1);
    send_packet(64'd0, 16'd0);   // backwards step: elapsed overflows
    drain();

    // Packet mode, band count past the band limit, rate ties
    commit_band(2'd0, 32'd10, 63'd15, 63'd0, 1'b1);
    commit_band(2'd1, 32'd10, 63'd15, 63'd0, 1'b0);
    commit_band(2'd2, 32'd10, 63'd25, 63'd9, 1'b0);
    commit_band(2'd3, 32'd10, 63'd25, 63'd9, 1'b1);
    cfg_write(CFG_PPS_MODE, 64'd1);
    cfg_write(CFG_BAND_COUNT, 64'd7);
    cfg_done();
    send_packet(64'd0, 16'd1500);
    send_packet(64'd0, 16'd64);
    send_packet(64'd0, 16'd9);
    send_packet(64'd10, 16'd100);
    drain();

    // Only a zero-rate band above band 0 drops: band 0 takes the drop
    commit_band(2'd0, 32'd0, 63'd0, 63'd0, 1'b0);
    commit_band(2'd1, 32'd10, 63'd5, 63'd0, 1'b1);
    cfg_write(CFG_BAND_COUNT, 64'd2);
    cfg_done();
    send_packet(64'd10, 16'd1);
    send_packet(64'd10, 16'd1);
    drain();

    // Random phases
    for (p = 0; p < PHASES; p++) begin
      reconfigure(p == 0);
      gaps_on   = (p % 4 != 1);
      stalls_on = (p % 4 != 2);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 15);
        if (sel == 0) len = '0;
        else if (sel == 1) len = '1;
        else if (sel == 2) len = 16'($urandom);
        else len = 16'($urandom_range(40, 1500));
        sel = $urandom_range(0, 31);
        if (sel == 0) ts = {$urandom, $urandom};
        else if (sel == 1) ts = ts_now;
        else if (sel == 2) ts = ts_now - 64'($urandom_range(1, 1000));
        else ts = ts_now + 64'($urandom_range(0, 100000));
        send_packet(ts, len);
      end
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mbtbm_pkg.sv
rtl/multi_band_token_bucket_meter.sv
verif/mbtbm_verdict_checker.sv
verif/tb_multi_band_token_bucket_meter.sv
